FILE: rtl/orhb_pkg.sv
`default_nettype none

package orhb_pkg;

    // Fixed widths of the request and result fields.
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int CAP_MIN = 2;
    localparam int CAP_RESET = 16;

    // Request codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERWRITE = 2'd1,
        ST_EMPTY     = 2'd2
    } t_status;

    // Shift command shared by every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

`default_nettype wire

FILE: rtl/orhb_cell.sv
`default_nettype none

module orhb_cell
    import orhb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_shift            i_shift,
    input  wire logic [DATA_W-1:0] i_from_newer,
    input  wire logic [DATA_W-1:0] i_from_older,
    output logic      [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // A push takes the word from the newer neighbour, a pop the one from the older.
    always_comb begin
        n_data = r_data;
        if (i_shift.push) begin
            n_data = i_from_newer;
        end else if (i_shift.pop) begin
            n_data = i_from_older;
        end
    end

    // Payload register: no reset needed.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: rtl/overwriting_ring_history_buffer.sv
`default_nettype none

// History buffer that keeps the most recent words up to a programmable capacity.
// Requests arrive on start with i_req_type and i_write_data; one is taken at every
// clock edge where start is high and busy is low. busy stays low, so a request may
// be issued in every cycle, giving a throughput of one request per cycle.
// An insert stores a word and, when the buffer is already full, drops the oldest
// word. A remove returns the newest word, so removal behaves like a stack.
// Each request gives one result word in the next cycle: o_strobe is high for a single
// cycle with o_status, o_read_data, o_entry_count, o_is_full and o_is_empty.
// The receiver cannot stall; results must be taken as they appear.
// The words live in a chain of cells, newest in the first cell, and the whole
// chain shifts by one place for each insert and each remove that finds a word.
// Writing i_cfg_wdata with i_cfg_we sets the capacity (below 2 acts as 2, above the
// lesser of DEPTH and 31 acts as that value) and empties the buffer. Reset empties the
// buffer and sets the capacity to 16 (or DEPTH if smaller); no clearing pass is needed.
module overwriting_ring_history_buffer
    import orhb_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_req_type,
    input  wire logic [DATA_W-1:0]  i_write_data,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [DATA_W-1:0]       o_read_data,
    output logic [COUNT_W-1:0]      o_entry_count,
    output logic                    o_is_full,
    output logic                    o_is_empty
);

    // The capacity field cannot exceed its own range, so no more cells are useful.
    localparam int CAP_FIELD_MAX = (1 << COUNT_W) - 1;
    localparam int NCELL = (DEPTH < CAP_FIELD_MAX) ? DEPTH : CAP_FIELD_MAX;
    localparam int CAP_INIT = (CAP_RESET < NCELL) ? CAP_RESET : NCELL;

    logic               r_strobe;
    t_status            r_status;
    logic [DATA_W-1:0]  r_read_data;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_cap;

    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] n_cap;
    t_status            n_status;
    logic [DATA_W-1:0]  n_read_data;
    logic               w_accept;
    t_shift             w_shift;
    logic [DATA_W-1:0]  w_cell_data [NCELL];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Clamp a written capacity into the range the chain supports.
    always_comb begin
        if (int'(i_cfg_wdata) < CAP_MIN) begin
            n_cap = COUNT_W'(CAP_MIN);
        end else if (int'(i_cfg_wdata) > NCELL) begin
            n_cap = COUNT_W'(NCELL);
        end else begin
            n_cap = i_cfg_wdata;
        end
    end

    // Request decode: new count, status, returned word and the chain shift.
    always_comb begin
        n_count       = r_count;
        n_status      = ST_OK;
        n_read_data   = '0;
        w_shift.push  = 1'b0;
        w_shift.pop   = 1'b0;
        if (w_accept) begin
            if (i_req_type == REQ_INSERT) begin
                w_shift.push = 1'b1;
                if (r_count == r_cap) begin
                    n_status = ST_OVERWRITE;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
            end else if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                w_shift.pop = 1'b1;
                n_read_data = w_cell_data[0];
                n_count     = r_count - COUNT_W'(1);
            end
        end
    end

    // Chain of cells, newest word in cell zero.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [DATA_W-1:0] w_newer;
        logic [DATA_W-1:0] w_older;
        if (g == 0) begin : g_first
            assign w_newer = i_write_data;
        end else begin : g_inner
            assign w_newer = w_cell_data[g-1];
        end
        if (g == NCELL - 1) begin : g_last
            assign w_older = w_cell_data[g];
        end else begin : g_mid
            assign w_older = w_cell_data[g+1];
        end
        orhb_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_shift),
            .i_from_newer (w_newer),
            .i_from_older (w_older),
            .o_data       (w_cell_data[g])
        );
    end

    // Control state: count, capacity and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cap    <= COUNT_W'(CAP_INIT);
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (i_cfg_we) begin
                r_count <= '0;
                r_cap   <= n_cap;
            end else begin
                r_count <= n_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_read_data <= n_read_data;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_entry_count = r_count;
    assign o_is_full     = (r_count == r_cap);
    assign o_is_empty    = (r_count == '0);

    // The fill count never runs past the capacity in use.
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    // Every accepted request gives exactly one result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("accepted request gave no result");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_strobe)
        else $error("result without a request");

    // A capacity write empties the buffer.
    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_count == '0))
        else $error("capacity write did not empty the buffer");

    // A failed remove returns no word.
    a_empty_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_EMPTY)) |-> (o_read_data == '0))
        else $error("remove from empty returned data");

endmodule

`default_nettype wire
